>>> rtl/afpp_pkg.sv
`timescale 1ns / 1ps

package afpp_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int OPCODE_W          = 2;
   localparam int LOOP_LENGTH_W     = 13;
   localparam int LOOP_LENGTH_RESET = 4096;
   localparam int STORE_DEPTH_DEF   = 4096;

   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic [LOOP_LENGTH_W-1:0]    loop_length_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK       = 2'd0,
      OP_FREEZE_ON  = 2'd1,
      OP_FREEZE_OFF = 2'd2
   } opcode_type;

endpackage

>>> rtl/afpp_channels.sv
`timescale 1ns / 1ps

// Input word: command plus incoming sample.
interface afpp_req_if;
   logic                 valid;
   logic                 ready;
   afpp_pkg::opcode_type opcode;
   afpp_pkg::sample_type in_sample;

   modport source (output valid, output opcode, output in_sample, input ready);
   modport sink   (input valid, input opcode, input in_sample, output ready);
endinterface

// Result word: one per sample tick.
interface afpp_rsp_if;
   logic                 valid;
   logic                 ready;
   afpp_pkg::sample_type out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

// Loop length register write.
interface afpp_csr_if;
   logic                      valid;
   logic                      ready;
   afpp_pkg::loop_length_type loop_length;

   modport source (output valid, output loop_length, input ready);
   modport sink   (input valid, input loop_length, output ready);
endinterface

>>> rtl/audio_freeze_ping_pong_looper.sv
// A sample tick's result word is registered: it is valid on rsp_ch right after the edge
//   that accepts the tick, ready to be taken at the next edge; commands give none.
// Throughput: one input word per cycle, set by the single-port-write / single-read
//   sample store; req_ch stalls only while a finished result word waits on rsp_ch.
// Reset (synchronous, active high): not frozen, positions and direction cleared, loop
//   length back to 4096 clamped to the store depth; the sample store is not cleared.
`timescale 1ns / 1ps

module audio_freeze_ping_pong_looper #(
   parameter int STORE_DEPTH = afpp_pkg::STORE_DEPTH_DEF
) (
   input logic     clock,
   input logic     reset,
   afpp_req_if.sink   req_ch,
   afpp_rsp_if.source rsp_ch,
   afpp_csr_if.sink   csr_ch
);
   import afpp_pkg::*;

   // AW addresses the store, LW holds a length up to STORE_DEPTH itself.
   localparam int AW = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
   localparam int LW = AW + 1;
   localparam int CW = (LW > LOOP_LENGTH_W) ? LW : LOOP_LENGTH_W;
   localparam int RESET_LEN =
      (LOOP_LENGTH_RESET > STORE_DEPTH) ? STORE_DEPTH : LOOP_LENGTH_RESET;

   // ------------------------------------------------------------------
   // Loop length register, kept already clamped to [2, STORE_DEPTH],
   // along with its last index so the turn compare is a plain compare.
   // ------------------------------------------------------------------
   logic [LW-1:0] len_ff,  len_in;
   logic [AW-1:0] last_ff, last_in;
   logic [CW-1:0] csr_len_wide;

   assign csr_ch.ready = 1'b1;
   assign csr_len_wide = CW'(csr_ch.loop_length);

   always_comb begin
      if (csr_len_wide < CW'(2)) begin
         len_in = LW'(2);
      end else if (csr_len_wide > CW'(STORE_DEPTH)) begin
         len_in = LW'(STORE_DEPTH);
      end else begin
         len_in = LW'(csr_len_wide);
      end
      last_in = AW'(len_in - LW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LW'(RESET_LEN);
         last_ff <= AW'(RESET_LEN - 1);
      end else if (csr_ch.valid) begin
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake. The result register parts the two sides: a new word is
   // taken whenever the result slot is empty or being drained this cycle.
   // ------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   opcode_type op;
   logic       is_tick;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign op           = req_ch.opcode;
   assign is_tick      = (op == OP_TICK);

   // ------------------------------------------------------------------
   // Control state and next-state logic.
   // ------------------------------------------------------------------
   logic          recording_ff,  recording_in;
   logic          playing_ff,    playing_in;
   logic          going_back_ff, going_back_in;
   logic [AW-1:0] write_pos_ff,  write_pos_in;
   logic [AW-1:0] read_pos_ff,   read_pos_in;
   logic [LW-1:0] write_pos_inc;
   logic          store_we;
   logic          store_re;

   assign write_pos_inc = {1'b0, write_pos_ff} + LW'(1);
   assign store_we      = req_fire && is_tick && recording_ff;
   assign store_re      = req_fire && is_tick;

   always_comb begin
      recording_in  = recording_ff;
      playing_in    = playing_ff;
      going_back_in = going_back_ff;
      write_pos_in  = write_pos_ff;
      read_pos_in   = read_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      if (req_fire) begin
         unique case (op)
            OP_FREEZE_ON: begin
               recording_in  = 1'b1;
               playing_in    = 1'b1;
               going_back_in = 1'b0;
               write_pos_in  = '0;
               read_pos_in   = '0;
            end
            OP_FREEZE_OFF: begin
               recording_in = 1'b0;
               playing_in   = 1'b0;
            end
            OP_TICK: begin
               rsp_valid_in = 1'b1;
               if (recording_ff) begin
                  if (write_pos_inc >= len_ff) begin
                     recording_in = 1'b0;
                     write_pos_in = '0;
                  end else begin
                     write_pos_in = AW'(write_pos_inc);
                  end
               end
               if (playing_ff) begin
                  // ping-pong between 0 and length-1; a position left past
                  // the end by a shorter length also turns back
                  if (!going_back_ff) begin
                     if (read_pos_ff >= last_ff) begin
                        going_back_in = 1'b1;
                        read_pos_in   = read_pos_ff - AW'(1);
                     end else begin
                        read_pos_in   = read_pos_ff + AW'(1);
                     end
                  end else begin
                     if (read_pos_ff == '0) begin
                        going_back_in = 1'b0;
                        read_pos_in   = read_pos_ff + AW'(1);
                     end else begin
                        read_pos_in   = read_pos_ff - AW'(1);
                     end
                  end
               end
            end
            default: begin
               // unused code: no state change, no word
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff  <= 1'b0;
         playing_ff    <= 1'b0;
         going_back_ff <= 1'b0;
         write_pos_ff  <= '0;
         read_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         recording_ff  <= recording_in;
         playing_ff    <= playing_in;
         going_back_ff <= going_back_in;
         write_pos_ff  <= write_pos_in;
         read_pos_ff   <= read_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Sample store: one write and one registered read per cycle. The
   // read returns old data, so a same-tick write to the read address is
   // forwarded from the incoming sample.
   // ------------------------------------------------------------------
   sample_type store_mem [STORE_DEPTH];
   sample_type rd_data_ff;
   sample_type fwd_sample_ff;
   logic       fwd_sel_ff;
   logic       play_sel_ff;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[write_pos_ff] <= req_ch.in_sample;
      end
      if (store_re) begin
         rd_data_ff <= store_mem[read_pos_ff];
      end
   end

   // payload side of the result register
   always_ff @(posedge clock) begin
      if (store_re) begin
         fwd_sample_ff <= req_ch.in_sample;
         fwd_sel_ff    <= recording_ff && (write_pos_ff == read_pos_ff);
         play_sel_ff   <= playing_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_sample = !play_sel_ff ? sample_type'(0) :
                              (fwd_sel_ff ? fwd_sample_ff : rd_data_ff);

`ifndef SYNTHESIS
   // a sample tick always yields a word in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && is_tick |=> rsp_valid_ff)
      else $error("tick accepted without result word");

   // commands never yield a word
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_tick |=> !rsp_valid_ff)
      else $error("result word after a command");

   // freeze on restarts capture and playback from index zero
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == OP_FREEZE_ON) |=>
         recording_ff && playing_ff && !going_back_ff &&
         (write_pos_ff == '0) && (read_pos_ff == '0))
      else $error("freeze on did not restart the loop");

   // capture only happens inside a frozen period
   assert property (@(posedge clock) disable iff (reset)
      recording_ff |-> playing_ff)
      else $error("recording while not playing");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import afpp_pkg::*;

   // Store depth of the instance, also the clamp ceiling of loop_length.
   localparam int unsigned LOOP_DEPTH = STORE_DEPTH_DEF;
   // Opcode the block must ignore (no state change, no word out).
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_WORDS   = 700;
   localparam int LONG_TICKS     = 300;   // ticks of the long capture at the top clamp
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
   localparam int HOLD_PHASE     = 2;
   localparam int SETTLE_CYCLES  = 4;     // margin for the block to settle after the last owed word
   localparam int WATCHDOG_LIMIT = 3000;  // several times hold-off plus worst gaps

   logic clock = 1'b0;
   logic reset;

   afpp_req_if req_ch ();
   afpp_rsp_if rsp_ch ();
   afpp_csr_if csr_ch ();

   audio_freeze_ping_pong_looper #(
      .STORE_DEPTH(LOOP_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Looper predictor: own copy of the loop memory, positions and modes.
   // ---------------------------------------------------------------------
   sample_type      loop_mem [LOOP_DEPTH];
   bit              captured [LOOP_DEPTH];   // entry written at least once since reset
   int unsigned     wr_idx;
   int unsigned     rd_idx;
   bit              capturing;
   bit              frozen;
   bit              reversing;
   loop_length_type loop_len_reg;

   sample_type played_q [$];   // samples the looper still owes on rsp_ch
   int         bad_words;
   int         words_sent;     // words that reach the block's logic (unused opcode excluded)
   bit         idle_en;        // both sides draw random gaps when set
   bit         hold_rsp_req;   // ask the receiver for one long hold-off
   int         quiet_cycles = 0;

   // loop_length clamped to [2, depth]
   function automatic int unsigned loop_span();
      if (loop_len_reg < 2) return 2;
      if (loop_len_reg > LOOP_DEPTH) return LOOP_DEPTH;
      return loop_len_reg;
   endfunction

   // A tick while frozen plays rd_idx after this tick's capture; it must hit
   // an entry that holds real data.
   function automatic bit read_is_defined();
      return !frozen || captured[rd_idx] || (capturing && wr_idx == rd_idx);
   endfunction

   function automatic void step_looper(input logic [1:0] op, input sample_type smp,
                                       output bit has_word, output sample_type played);
      int unsigned span;
      span     = loop_span();
      has_word = 1'b0;
      played   = '0;
      case (op)
         OP_FREEZE_ON: begin
            capturing = 1'b1;
            frozen    = 1'b1;
            wr_idx    = 0;
            rd_idx    = 0;
            reversing = 1'b0;
         end
         OP_FREEZE_OFF: begin
            // positions stay where they are
            capturing = 1'b0;
            frozen    = 1'b0;
         end
         OP_TICK: begin
            has_word = 1'b1;
            // capture first, so a tick can play what it just stored
            if (capturing) begin
               if (wr_idx < LOOP_DEPTH) begin
                  loop_mem[wr_idx] = smp;
                  captured[wr_idx] = 1'b1;
               end
               wr_idx++;
               if (wr_idx >= span) begin
                  capturing = 1'b0;
                  wr_idx    = 0;
               end
            end
            if (frozen) begin
               if (rd_idx < LOOP_DEPTH) played = loop_mem[rd_idx];
               if (!reversing) begin
                  // >= also folds back a position left past a shrunken loop
                  if (rd_idx >= span - 1) begin
                     reversing = 1'b1;
                     rd_idx--;
                  end else begin
                     rd_idx++;
                  end
               end else begin
                  if (rd_idx == 0) begin
                     reversing = 1'b0;
                     rd_idx++;
                  end else begin
                     rd_idx--;
                  end
               end
            end
         end
         default: ;   // unused opcode: nothing happens
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Offer one word, wait for the handshake, then predict. A typed value,
   // when given, replaces the prediction as the owed sample.
   task automatic send_word(input logic [1:0] op, input sample_type smp,
                            input bit typed, input sample_type want);
      int unsigned gap;
      bit          has_word;
      sample_type  played;
      gap = idle_en ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.opcode    = opcode_type'(op);
      req_ch.in_sample = smp;
      do @(posedge clock); while (!req_ch.ready);
      step_looper(op, smp, has_word, played);
      if (has_word) played_q.push_back(typed ? want : played);
      if (op != OP_UNUSED) words_sent++;
   endtask

   task automatic send_random_word();
      logic [1:0]  op;
      sample_type  smp;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      smp  = 16'($urandom());
      if ($urandom_range(0, 15) == 0)
         smp = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      if (pick < 80)      op = OP_TICK;
      else if (pick < 88) op = OP_FREEZE_ON;
      else if (pick < 95) op = OP_FREEZE_OFF;
      else                op = OP_UNUSED;
      // playing an entry never captured since reset is off limits
      // (e.g. loop grew during playback): restart the capture instead
      if (op == OP_TICK && !read_is_defined()) op = OP_FREEZE_ON;
      send_word(op, smp, 1'b0, '0);
   endtask

   // Stop offering, let every owed word out, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (played_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_loop_length(input loop_length_type len);
      @(negedge clock);
      csr_ch.valid       = 1'b1;
      csr_ch.loop_length = len;
      do @(posedge clock); while (!csr_ch.ready);
      loop_len_reg = len;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Mostly short loops; now and then the clamps and the full store.
   function automatic loop_length_type pick_loop_length();
      case ($urandom_range(0, 9))
         0: return 13'($urandom_range(0, 1));
         1: begin
            case ($urandom_range(0, 3))
               0:       return 13'd4095;
               1:       return 13'd4096;
               2:       return 13'd4097;
               default: return 13'd8191;
            endcase
         end
         2:       return 13'($urandom_range(25, 400));
         default: return 13'($urandom_range(2, 24));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Directed table: reset state, sample extremes, every opcode, both turns,
   // length clamp at the bottom, restart while playing.
   // ---------------------------------------------------------------------
   typedef struct packed {
      bit              is_cfg;
      logic [1:0]      op;
      sample_type      smp;
      bit              typed;
      sample_type      want;
      loop_length_type cfg_val;
   } stim_row_type;

   stim_row_type dir_rows [0:23] = '{
      // not frozen after reset: ticks play silence
      '{1'b0, OP_TICK,       16'sh7FFF, 1'b1, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh8000, 1'b1, 16'sh0000, 13'd0},
      '{1'b0, OP_UNUSED,     16'sh1234, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_FREEZE_OFF, 16'sh0000, 1'b0, 16'sh0000, 13'd0},
      // capture and play in lockstep: each tick plays what it just wrote
      '{1'b0, OP_FREEZE_ON,  16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh7FFF, 1'b1, 16'sh7FFF, 13'd0},
      '{1'b0, OP_TICK,       16'sh8000, 1'b1, 16'sh8000, 13'd0},
      '{1'b0, OP_TICK,       16'shFFFF, 1'b1, 16'shFFFF, 13'd0},
      '{1'b0, OP_FREEZE_OFF, 16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh1234, 1'b1, 16'sh0000, 13'd0},
      '{1'b0, OP_FREEZE_ON,  16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'shAAAA, 1'b1, 16'shAAAA, 13'd0},
      // length 0 clamps to 2: forward and backward turns come quickly
      '{1'b1, OP_TICK,       16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_FREEZE_ON,  16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh0101, 1'b1, 16'sh0101, 13'd0},
      '{1'b0, OP_TICK,       16'sh0202, 1'b1, 16'sh0202, 13'd0},
      '{1'b0, OP_TICK,       16'sh0303, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh0404, 1'b0, 16'sh0000, 13'd0},
      // length 1 also clamps to 2, playback carries on
      '{1'b1, OP_TICK,       16'sh0000, 1'b0, 16'sh0000, 13'd1},
      '{1'b0, OP_TICK,       16'sh0505, 1'b0, 16'sh0000, 13'd0},
      // restart in the middle of playback
      '{1'b0, OP_FREEZE_ON,  16'sh0000, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh0606, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh0707, 1'b0, 16'sh0000, 13'd0},
      '{1'b0, OP_TICK,       16'sh0808, 1'b0, 16'sh0000, 13'd0}
   };

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int unsigned n_items;
      int          phase;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_TICK;
      req_ch.in_sample   = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.loop_length = '0;
      bad_words          = 0;
      words_sent         = 0;
      idle_en            = 1'b1;
      hold_rsp_req       = 1'b0;
      wr_idx             = 0;
      rd_idx             = 0;
      capturing          = 1'b0;
      frozen             = 1'b0;
      reversing          = 1'b0;
      loop_len_reg       = LOOP_LENGTH_RESET;
      foreach (captured[i]) captured[i] = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain();
            write_loop_length(dir_rows[i].cfg_val);
         end else begin
            send_word(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases: new length while idle, then mostly a capture restart
      // followed by ticks, with some freeze-off and ignored noise mixed in.
      words_sent = 0;
      phase      = 0;
      while (words_sent < RANDOM_WORDS) begin
         drain();
         write_loop_length(pick_loop_length());
         idle_en = ($urandom_range(0, 3) != 0);
         n_items = $urandom_range(4, 120);
         if (phase == HOLD_PHASE) begin
            // sender keeps pushing back to back while the receiver sits still
            idle_en      = 1'b0;
            hold_rsp_req = 1'b1;
            n_items      = 60;
         end
         if ($urandom_range(0, 3) != 0) send_word(OP_FREEZE_ON, '0, 1'b0, '0);
         repeat (n_items) send_random_word();
         phase++;
      end

      // A long capture with the length at its top clamp.
      drain();
      idle_en = 1'b0;
      write_loop_length(13'd8191);
      send_word(OP_FREEZE_ON, '0, 1'b0, '0);
      repeat (LONG_TICKS) send_word(OP_TICK, 16'($urandom()), 1'b0, '0);

      drain();
      repeat (8) @(posedge clock);
      if (bad_words == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall per word, one long hold-off on request, and the
   // field check against the oldest owed sample.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned stall;
      sample_type  owed;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp_req = 1'b0;
         end else if (idle_en) begin
            stall = $urandom_range(0, 19);
            if (stall != 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (played_q.size() == 0) begin
            $error("out_sample: no word owed, actual %0d", rsp_ch.out_sample);
            bad_words++;
         end else begin
            owed = played_q.pop_front();
            if (rsp_ch.out_sample !== owed) begin
               $error("out_sample mismatch: expected %0d, actual %0d", owed,
                      rsp_ch.out_sample);
               bad_words++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
